// File: hw/rtl/dmwp_pkg.sv
// ----------------------------------------------------------------------------
// Wheel plant package
// Shared constants, register map, arithmetic-unit request and response types,
// and saturation helpers for the motor-driven wheel plant step block.
// ----------------------------------------------------------------------------
package dmwp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int RST_FRAC      = 16;

  localparam int CFG_NUM = 7;
  localparam int CFG_IW  = 3;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int REG_W   = 31;

  localparam logic [CFG_IW-1:0] REG_STALL     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_NO_LOAD   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_INERTIA   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MASS      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_RADIUS    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_FRICTION  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_TIME_STEP = 3'd6;

  // Reset values in unsigned Q15.16; rescaled to the configured fraction width.
  localparam logic [REG_W-1:0] RST_STALL_Q16     = 31'd6422528;
  localparam logic [REG_W-1:0] RST_NO_LOAD_Q16   = 31'd1212416;
  localparam logic [REG_W-1:0] RST_INERTIA_Q16   = 31'd65536;
  localparam logic [REG_W-1:0] RST_MASS_Q16      = 31'd655360;
  localparam logic [REG_W-1:0] RST_RADIUS_Q16    = 31'd32768;
  localparam logic [REG_W-1:0] RST_FRICTION_Q16  = 31'd196608;
  localparam logic [REG_W-1:0] RST_TIME_STEP_Q16 = 31'd6554;

  localparam logic [7:0]  CODE_OFF  = 8'd0;
  localparam logic [7:0]  CODE_STOP = 8'd128;
  localparam logic [31:0] GAIN_DIV  = 32'd127;

  localparam int DIV_BITS = 2;
  localparam int DIV_ITER = 32 / DIV_BITS;
  localparam int CNT_W    = $clog2(DIV_ITER);

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [REG_W-1:0] stall_torque;
    logic [REG_W-1:0] no_load_speed;
    logic [REG_W-1:0] wheel_inertia;
    logic [REG_W-1:0] wheel_mass;
    logic [REG_W-1:0] wheel_radius;
    logic [REG_W-1:0] friction_coeff;
    logic [REG_W-1:0] time_step;
  } cfg_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [63:0] res;
  } alu_rsp_t;

  function automatic logic [33:0] sx34(input logic [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] s;
    if (v > $signed(sx34(S32_MAX))) begin
      s = S32_MAX;
    end else if (v < $signed(sx34(S32_MIN))) begin
      s = S32_MIN;
    end else begin
      s = v[31:0];
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] m);
    logic signed [31:0] s;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        s = S32_MIN;
      end else begin
        s = ~m[31:0] + 32'd1;
      end
    end else begin
      if (m > 64'h7FFF_FFFF) begin
        s = S32_MAX;
      end else begin
        s = m[31:0];
      end
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/dmwp_cfg.sv
// ----------------------------------------------------------------------------
// Wheel plant configuration registers
// APB-style register file holding the seven 31-bit plant parameters.
// ----------------------------------------------------------------------------
module dmwp_cfg #(
  parameter int FRAC_BITS = dmwp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmwp_pkg::CFG_AW-1:0]   paddr,
  input  logic [dmwp_pkg::CFG_DW-1:0]   pwdata,
  output logic [dmwp_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output dmwp_pkg::cfg_t                cfg
);
  import dmwp_pkg::*;

  localparam logic [REG_W-1:0] RST_VAL [CFG_NUM] = '{
    REG_W'((64'(RST_STALL_Q16)     << FRAC_BITS) >> RST_FRAC),
    REG_W'((64'(RST_NO_LOAD_Q16)   << FRAC_BITS) >> RST_FRAC),
    REG_W'((64'(RST_INERTIA_Q16)   << FRAC_BITS) >> RST_FRAC),
    REG_W'((64'(RST_MASS_Q16)      << FRAC_BITS) >> RST_FRAC),
    REG_W'((64'(RST_RADIUS_Q16)    << FRAC_BITS) >> RST_FRAC),
    REG_W'((64'(RST_FRICTION_Q16)  << FRAC_BITS) >> RST_FRAC),
    REG_W'((64'(RST_TIME_STEP_Q16) << FRAC_BITS) >> RST_FRAC)
  };

  logic [REG_W-1:0]  regs_r [CFG_NUM];
  logic [CFG_IW-1:0] idx;
  logic              wr_en;

  assign idx    = paddr[CFG_IW+1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        regs_r[i] <= RST_VAL[i];
      end
    end else if (wr_en && (32'(idx) < 32'(CFG_NUM))) begin
      regs_r[idx] <= pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(idx) < 32'(CFG_NUM)) begin
      prdata = {1'b0, regs_r[idx]};
    end
  end

  assign cfg.stall_torque   = regs_r[REG_STALL];
  assign cfg.no_load_speed  = regs_r[REG_NO_LOAD];
  assign cfg.wheel_inertia  = regs_r[REG_INERTIA];
  assign cfg.wheel_mass     = regs_r[REG_MASS];
  assign cfg.wheel_radius   = regs_r[REG_RADIUS];
  assign cfg.friction_coeff = regs_r[REG_FRICTION];
  assign cfg.time_step      = regs_r[REG_TIME_STEP];

endmodule

// File: hw/rtl/dmwp_alu.sv
// ----------------------------------------------------------------------------
// Wheel plant shared arithmetic unit
// Unsigned 32x32 multiplier with a registered product, and a restoring
// divider of a 64-bit dividend by a 32-bit divisor, two quotient bits a cycle.
// ----------------------------------------------------------------------------
module dmwp_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  dmwp_pkg::alu_req_t req,
  output dmwp_pkg::alu_rsp_t rsp
);
  import dmwp_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      quo_r, quo_nxt;
  logic [31:0]      den_r, den_nxt;
  logic [63:0]      res_r, res_nxt;
  logic [63:0]      mul_p;
  logic [32:0]      trial;
  logic [31:0]      rem_t;
  logic [31:0]      quo_t;

  assign mul_p = req.a[31:0] * req.b;

  always_comb begin
    rem_t = rem_r;
    quo_t = quo_r;
    trial = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_t, quo_t[31]};
      quo_t = {quo_t[30:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial    = trial - {1'b0, den_r};
        quo_t[0] = 1'b1;
      end
      rem_t = trial[31:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    res_nxt  = res_r;
    if (busy_r) begin
      rem_nxt = rem_t;
      quo_nxt = quo_t;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_ITER - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = {32'd0, quo_t};
      end
    end else if (req.start) begin
      case (req.op)
        ALU_MUL: begin
          res_nxt  = mul_p;
          ovf_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
        ALU_DIV: begin
          if (req.a[63:32] >= req.b) begin
            ovf_nxt  = 1'b1;
            done_nxt = 1'b1;
          end else begin
            ovf_nxt  = 1'b0;
            busy_nxt = 1'b1;
            cnt_nxt  = '0;
            rem_nxt  = req.a[63:32];
            quo_nxt  = req.a[31:0];
            den_nxt  = req.b;
          end
        end
        default: begin
          done_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.res  = res_r;

endmodule

// File: hw/rtl/dc_motor_wheel_plant_step.sv
// ----------------------------------------------------------------------------
// Motor-driven wheel plant step
// Fixed-point plant model of a motor-driven wheel, advanced one Euler step
// per tick beat.
//
// The input stream carries one beat per command: in_tuser is the command
// (0 stores the drive code in in_tdata[7:0], 1 advances one time step).
// A set-drive beat produces nothing. A tick produces one output beat holding
// the new angular speed, linear speed and wheel angle. The seven plant
// parameters are written through the APB-style cfg_ port; the user must
// write them only while the block is idle. The block does not enforce this.
// A tick runs on one shared unit under a sequencer. A divide whose quotient
// overflows 32 bits finishes without iterating. When the drive gain is zero
// the torque-speed multiplies and divides are skipped. in_tready is low while
// a tick is in progress.
// If the receiver stalls, the finished beat waits in the output register;
// the next command is still accepted, and a later tick holds its result
// until that register is free. Reset clears the held drive code, speed and
// angle, and loads the default parameters.
// ----------------------------------------------------------------------------
module dc_motor_wheel_plant_step #(
  parameter int FRAC_BITS = dmwp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] drive_code
  input  logic                          in_tuser,   // [0] command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] angular_speed, [63:32] linear_speed, [95:64] wheel_angle
  output logic [95:0]                   out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dmwp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [dmwp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [dmwp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import dmwp_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_R2    = 14'b00000000000010,
    ST_WT    = 14'b00000000000100,
    ST_SLOPE = 14'b00000000001000,
    ST_CG    = 14'b00000000010000,
    ST_SCALE = 14'b00000000100000,
    ST_CW    = 14'b00000001000000,
    ST_FR    = 14'b00000010000000,
    ST_MR    = 14'b00000100000000,
    ST_ALPHA = 14'b00001000000000,
    ST_WDT   = 14'b00010000000000,
    ST_ADT   = 14'b00100000000000,
    ST_LIN   = 14'b01000000000000,
    ST_EMIT  = 14'b10000000000000
  } state_t;

  cfg_t     cfg;
  alu_req_t req;
  alu_rsp_t rsp;

  state_t             state_r, state_nxt;
  logic               go_r, go_nxt;
  logic [7:0]         code_r, code_nxt;
  logic signed [31:0] w_r, w_nxt;
  logic signed [31:0] ang_r, ang_nxt;
  logic [REG_W-1:0]   r2_r, r2_nxt;
  logic [61:0]        prod_r, prod_nxt;
  logic signed [31:0] slope_r, slope_nxt;
  logic signed [32:0] drive_r, drive_nxt;
  logic signed [31:0] f1_r, f1_nxt;
  logic signed [31:0] torque_r, torque_nxt;
  logic [REG_W-1:0]   denom_r, denom_nxt;
  logic signed [31:0] alpha_r, alpha_nxt;
  logic signed [31:0] lin_r, lin_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [95:0]        out_data_r, out_data_nxt;

  logic               op_neg;
  logic               op_zero;
  logic               gpos;
  logic               gzero;
  logic [7:0]         g_mag;
  logic signed [33:0] curve;
  logic [31:0]        curve_mag;
  logic signed [31:0] mul_q;
  logic signed [31:0] div_val;
  logic signed [31:0] sum_q;
  logic [63:0]        prod_sh;

  dmwp_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dmwp_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign gpos  = code_r > CODE_STOP;
  assign gzero = (code_r == CODE_OFF) || (code_r == CODE_STOP);
  assign g_mag = gpos ? (code_r - CODE_STOP) : (CODE_STOP - code_r);

  assign curve = gpos ? ({3'b000, cfg.stall_torque} + sx34(slope_r))
                      : ({3'b000, cfg.stall_torque} - sx34(slope_r));
  assign curve_mag = curve[33] ? 32'(34'd0 - curve) : curve[31:0];

  assign prod_sh = rsp.res >> FRAC_BITS;
  assign mul_q   = sat_mag(op_neg, prod_sh);

  always_comb begin
    if (op_zero) begin
      div_val = '0;
    end else if (rsp.ovf) begin
      div_val = op_neg ? S32_MIN : S32_MAX;
    end else begin
      div_val = sat_mag(op_neg, {32'd0, rsp.res[31:0]});
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    req.start = go_r;
    req.op    = ALU_MUL;
    req.a     = '0;
    req.b     = '0;
    op_neg    = 1'b0;
    op_zero   = 1'b0;
    case (state_r)
      ST_R2: begin
        req.a = {33'd0, cfg.wheel_radius};
        req.b = {1'b0, cfg.wheel_radius};
      end
      ST_WT: begin
        req.a = {32'd0, abs32(w_r)};
        req.b = {1'b0, cfg.stall_torque};
      end
      ST_SLOPE: begin
        req.op  = ALU_DIV;
        req.a   = {2'b00, prod_r};
        req.b   = {1'b0, cfg.no_load_speed};
        op_neg  = w_r[31];
        op_zero = (prod_r == '0);
      end
      ST_CG: begin
        req.a = {32'd0, curve_mag};
        req.b = {24'd0, g_mag};
      end
      ST_SCALE: begin
        req.op  = ALU_DIV;
        req.a   = {2'b00, prod_r};
        req.b   = GAIN_DIV;
        op_neg  = curve[33];
        op_zero = (prod_r == '0);
      end
      ST_CW: begin
        req.a  = {33'd0, cfg.friction_coeff};
        req.b  = abs32(w_r);
        op_neg = w_r[31];
      end
      ST_FR: begin
        req.a  = {32'd0, abs32(f1_r)};
        req.b  = {1'b0, r2_r};
        op_neg = f1_r[31];
      end
      ST_MR: begin
        req.a = {33'd0, cfg.wheel_mass};
        req.b = {1'b0, r2_r};
      end
      ST_ALPHA: begin
        req.op  = ALU_DIV;
        req.a   = {32'd0, abs32(torque_r)} << FRAC_BITS;
        req.b   = {1'b0, denom_r};
        op_neg  = torque_r[31];
        op_zero = (torque_r == '0);
      end
      ST_WDT: begin
        req.a  = {32'd0, abs32(w_r)};
        req.b  = {1'b0, cfg.time_step};
        op_neg = w_r[31];
      end
      ST_ADT: begin
        req.a  = {32'd0, abs32(alpha_r)};
        req.b  = {1'b0, cfg.time_step};
        op_neg = alpha_r[31];
      end
      ST_LIN: begin
        req.a  = {32'd0, abs32(w_r)};
        req.b  = {1'b0, cfg.wheel_radius};
        op_neg = w_r[31];
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    sum_q = '0;
    case (state_r)
      ST_FR:   sum_q = sat34({drive_r[32], drive_r} - sx34(mul_q));
      ST_MR:   sum_q = sat34({3'b000, cfg.wheel_inertia} + sx34(mul_q));
      ST_WDT:  sum_q = sat34(sx34(ang_r) + sx34(mul_q));
      ST_ADT:  sum_q = sat34(sx34(w_r) + sx34(mul_q));
      ST_LIN:  sum_q = sat34(34'd0 - sx34(mul_q));
      default: sum_q = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    code_nxt      = code_r;
    w_nxt         = w_r;
    ang_nxt       = ang_r;
    r2_nxt        = r2_r;
    prod_nxt      = prod_r;
    slope_nxt     = slope_r;
    drive_nxt     = drive_r;
    f1_nxt        = f1_r;
    torque_nxt    = torque_r;
    denom_nxt     = denom_r;
    alpha_nxt     = alpha_r;
    lin_nxt       = lin_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        drive_nxt = '0;
        if (in_tvalid) begin
          if (in_tuser) begin
            state_nxt = ST_R2;
            go_nxt    = 1'b1;
          end else begin
            code_nxt = in_tdata;
          end
        end
      end
      ST_R2: begin
        if (rsp.done) begin
          r2_nxt    = mul_q[REG_W-1:0];
          state_nxt = gzero ? ST_CW : ST_WT;
          go_nxt    = 1'b1;
        end
      end
      ST_WT: begin
        if (rsp.done) begin
          prod_nxt  = rsp.res[61:0];
          state_nxt = ST_SLOPE;
          go_nxt    = 1'b1;
        end
      end
      ST_SLOPE: begin
        if (rsp.done) begin
          slope_nxt = div_val;
          state_nxt = ST_CG;
          go_nxt    = 1'b1;
        end
      end
      ST_CG: begin
        if (rsp.done) begin
          prod_nxt  = rsp.res[61:0];
          state_nxt = ST_SCALE;
          go_nxt    = 1'b1;
        end
      end
      ST_SCALE: begin
        if (rsp.done) begin
          drive_nxt = gpos ? (33'd0 - {div_val[31], div_val}) : {div_val[31], div_val};
          state_nxt = ST_CW;
          go_nxt    = 1'b1;
        end
      end
      ST_CW: begin
        if (rsp.done) begin
          f1_nxt    = mul_q;
          state_nxt = ST_FR;
          go_nxt    = 1'b1;
        end
      end
      ST_FR: begin
        if (rsp.done) begin
          torque_nxt = sum_q;
          state_nxt  = ST_MR;
          go_nxt     = 1'b1;
        end
      end
      ST_MR: begin
        if (rsp.done) begin
          denom_nxt = sum_q[REG_W-1:0];
          state_nxt = ST_ALPHA;
          go_nxt    = 1'b1;
        end
      end
      ST_ALPHA: begin
        if (rsp.done) begin
          alpha_nxt = div_val;
          state_nxt = ST_WDT;
          go_nxt    = 1'b1;
        end
      end
      ST_WDT: begin
        if (rsp.done) begin
          ang_nxt   = sum_q;
          state_nxt = ST_ADT;
          go_nxt    = 1'b1;
        end
      end
      ST_ADT: begin
        if (rsp.done) begin
          w_nxt     = sum_q;
          state_nxt = ST_LIN;
          go_nxt    = 1'b1;
        end
      end
      ST_LIN: begin
        if (rsp.done) begin
          lin_nxt   = sum_q;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ang_r, lin_r, w_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      code_r      <= CODE_OFF;
      w_r         <= '0;
      ang_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      code_r      <= code_nxt;
      w_r         <= w_nxt;
      ang_r       <= ang_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r2_r       <= r2_nxt;
    prod_r     <= prod_nxt;
    slope_r    <= slope_nxt;
    drive_r    <= drive_nxt;
    f1_r       <= f1_nxt;
    torque_r   <= torque_nxt;
    denom_r    <= denom_nxt;
    alpha_r    <= alpha_nxt;
    lin_r      <= lin_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
